/* rtl/tcf_pkg.sv */
// ----------------------------------------------------------------------------
// tcf_pkg: shared types and constants
// window depth, channel count, histogram geometry and sequencer state codes
// ----------------------------------------------------------------------------
package tcf_pkg;
   localparam int WindowDepth  = 6;
   localparam int NumChannels  = 128;
   localparam int ChanBits     = 7;
   localparam int HistAddrBits = 3 * ChanBits;
   localparam int HistDepth    = 1 << HistAddrBits;
   localparam int CountWidth   = 32;
   localparam int SlotBits     = 3;
   localparam int FillBits     = 3;
   localparam logic [31:0] CountCap = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [62:0] time_stamp;
      logic [63:0] word_eight;
      logic [7:0]  channel_byte;
      logic [55:0] word_seventeen;
      logic [63:0] word_twentyfour;
      logic [63:0] word_thirtytwo;
      logic [31:0] word_forty;
   } rec_type;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_CLEAR  = 11'b000_0000_0010,
      ST_EVICT  = 11'b000_0000_0100,
      ST_PAIR   = 11'b000_0000_1000,
      ST_RDWAIT = 11'b000_0001_0000,
      ST_UPDATE = 11'b000_0010_0000,
      ST_EMIT   = 11'b000_0100_0000,
      ST_STORE  = 11'b000_1000_0000,
      ST_QWAIT  = 11'b001_0000_0000,
      ST_QEMIT  = 11'b010_0000_0000,
      ST_QREAD  = 11'b100_0000_0000
   } state_type;
endpackage

/* rtl/tcf_ram.sv */
// ----------------------------------------------------------------------------
// tcf_ram: generic single-port ram
// one write or read per cycle, registered read data
// ----------------------------------------------------------------------------
module tcf_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule

/* rtl/tcf_sort3.sv */
// ----------------------------------------------------------------------------
// tcf_sort3: triple channel check and ranking
// tells whether three channels differ and gives each member's rank
// ----------------------------------------------------------------------------
module tcf_sort3
   import tcf_pkg::*;
(
   input  logic [ChanBits-1:0]     chan_a,
   input  logic [ChanBits-1:0]     chan_b,
   input  logic [ChanBits-1:0]     chan_c,
   output logic                    distinct,
   output logic [1:0]              rank_a,
   output logic [1:0]              rank_b,
   output logic [1:0]              rank_c,
   output logic [HistAddrBits-1:0] hist_addr
);
   logic ab, ac, bc;
   logic [ChanBits-1:0] lo, mid, hi;
   always_comb begin
      ab = chan_a > chan_b;
      ac = chan_a > chan_c;
      bc = chan_b > chan_c;
      distinct = (chan_a != chan_b) && (chan_a != chan_c) && (chan_b != chan_c);
      rank_a = 2'(ab) + 2'(ac);
      rank_b = 2'(!ab) + 2'(bc);
      rank_c = 2'(!ac) + 2'(!bc);
      lo  = chan_a; mid = chan_a; hi = chan_a;
      if (rank_b == 2'd0) lo = chan_b;
      if (rank_c == 2'd0) lo = chan_c;
      if (rank_a == 2'd1) mid = chan_a;
      if (rank_b == 2'd1) mid = chan_b;
      if (rank_c == 2'd1) mid = chan_c;
      if (rank_b == 2'd2) hi = chan_b;
      if (rank_c == 2'd2) hi = chan_c;
      if (rank_a == 2'd0) lo = chan_a;
      if (rank_a == 2'd2) hi = chan_a;
      hist_addr = {lo, mid, hi};
   end
endmodule

/* rtl/triple_coincidence_finder.sv */
// ----------------------------------------------------------------------------
// triple_coincidence_finder: sliding window triple coincidence detector
// one compare unit walks stored records, one histogram ram port per cycle
// ----------------------------------------------------------------------------
// sequence: a record beat first evicts stored records that fall outside the window,
//   then walks every stored pair; each found triple takes a ram read and an update
//   and emits one response beat per member, then the record is stored; a query reads
//   the ram, then emits; one beat at a time, held longer under response stalls
// reset: synchronous, then a histogram clearing pass over every entry, not ready
// ----------------------------------------------------------------------------
module triple_coincidence_finder
   import tcf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,   // mode
   // time_stamp, word_eight, channel_byte, word_seventeen, word_twentyfour,
   // word_thirtytwo, word_forty, query_index, zero fill
   input  logic [431:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic         rsp_tlast,
   // out_time_stamp .. out_word_forty, member_position, combination_count,
   // triples_total, window_overflowed, zero fill
   output logic [511:0] rsp_tdata
);
   logic [15:0] win_ff;
   state_type   st_ff;
   rec_type     win_rec_ff [WindowDepth];
   rec_type     new_ff;
   logic [FillBits-1:0] fill_ff, keep_ff, idx_ff, pa_ff, pb_ff;
   logic [HistAddrBits-1:0] clr_ff, haddr_ff, qaddr_ff;
   logic [63:0] total_ff;
   logic        ovf_ff, pend_ff;
   logic [1:0]  emit_ff;
   logic [1:0]  rk_ff [3];
   logic [31:0] cnt_ff;
   logic [511:0] out_ff;
   logic        ovalid_ff, olast_ff;
   logic        ovalid_in;

   rec_type     req_rec;
   logic [HistAddrBits-1:0] req_q;
   logic        distinct;
   logic [1:0]  ra, rb, rc;
   logic [HistAddrBits-1:0] paddr;
   logic        ram_we;
   logic [HistAddrBits-1:0] ram_addr;
   logic [31:0] ram_wd, ram_rd;
   logic [63:0] span, lhs;
   logic        out_free, last_pair;
   rec_type     mem_sel;
   logic [1:0]  pos_sel;
   logic [FillBits-1:0] pb_next;

   assign req_rec = '{time_stamp: req_tdata[62:0], word_eight: req_tdata[126:63],
                      channel_byte: req_tdata[134:127], word_seventeen: req_tdata[190:135],
                      word_twentyfour: req_tdata[254:191],
                      word_thirtytwo: req_tdata[318:255], word_forty: req_tdata[350:319]};
   assign req_q   = req_tdata[371:351];
   assign out_free = !ovalid_ff || rsp_tready;
   assign req_tready = (st_ff == ST_IDLE) && out_free;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = out_ff;

   tcf_sort3 u_sort (
      .chan_a(win_rec_ff[pa_ff].channel_byte[7:1]),
      .chan_b(win_rec_ff[pb_ff].channel_byte[7:1]),
      .chan_c(new_ff.channel_byte[7:1]),
      .distinct(distinct), .rank_a(ra), .rank_b(rb), .rank_c(rc),
      .hist_addr(paddr)
   );

   tcf_ram #(.Width(CountWidth), .Depth(HistDepth)) u_hist (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wd), .rd_data(ram_rd)
   );

   always_comb begin
      ram_we = 1'b0; ram_wd = ram_rd + 32'd1; ram_addr = haddr_ff;
      if (st_ff == ST_CLEAR) begin
         ram_we = 1'b1; ram_wd = '0; ram_addr = clr_ff;
      end else if (st_ff == ST_UPDATE) begin
         ram_we = ram_rd != CountCap;
      end else if (st_ff == ST_QREAD || st_ff == ST_QWAIT || st_ff == ST_QEMIT) begin
         ram_addr = qaddr_ff;
      end
      span = {38'd0, win_ff, 10'd0};
      lhs  = {1'b0, win_rec_ff[idx_ff].time_stamp} + span;
      last_pair = 1'b0;
      pb_next = pb_ff + 3'd1;
      if (pb_next >= fill_ff) last_pair = (pa_ff + 3'd2 >= fill_ff);
      mem_sel = new_ff; pos_sel = rk_ff[2];
      if (emit_ff == 2'd0) begin
         if (rk_ff[0] == 2'd0) mem_sel = win_rec_ff[pa_ff];
         if (rk_ff[1] == 2'd0) mem_sel = win_rec_ff[pb_ff];
      end else if (emit_ff == 2'd1) begin
         if (rk_ff[0] == 2'd1) mem_sel = win_rec_ff[pa_ff];
         if (rk_ff[1] == 2'd1) mem_sel = win_rec_ff[pb_ff];
      end else begin
         if (rk_ff[0] == 2'd2) mem_sel = win_rec_ff[pa_ff];
         if (rk_ff[1] == 2'd2) mem_sel = win_rec_ff[pb_ff];
      end
      pos_sel = emit_ff;
      // last beat of a triple waits until it is known whether another follows
      ovalid_in = ovalid_ff && !rsp_tready;
      if ((st_ff == ST_QEMIT && out_free) ||
          (st_ff == ST_EMIT && out_free && (emit_ff != 2'd2 || last_pair)) ||
          (st_ff == ST_PAIR && pend_ff && (distinct || last_pair)))
         ovalid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR; clr_ff <= '0; fill_ff <= '0; total_ff <= '0;
         ovf_ff <= 1'b0; ovalid_ff <= 1'b0; win_ff <= 16'd1; pend_ff <= 1'b0;
      end else begin
         if (csr_wr_en) win_ff <= csr_wr_data;
         ovalid_ff <= ovalid_in;
         unique case (st_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (&clr_ff) st_ff <= ST_IDLE;
            end
            ST_IDLE: if (req_tvalid && req_tready) begin
               if (req_tuser) begin
                  qaddr_ff <= req_q;
                  st_ff <= ST_QREAD;
               end else begin
                  new_ff <= req_rec; idx_ff <= '0; keep_ff <= '0;
                  st_ff <= ST_EVICT;
               end
            end
            ST_QREAD: st_ff <= ST_QWAIT;
            ST_QWAIT: st_ff <= ST_QEMIT;
            ST_QEMIT: if (out_free) begin
               out_ff <= {62'd0, ovf_ff, total_ff, ram_rd, 2'd0, 351'd0};
               olast_ff <= 1'b1; st_ff <= ST_IDLE;
            end
            ST_EVICT: begin
               if (idx_ff >= fill_ff) begin
                  fill_ff <= keep_ff; pa_ff <= '0; pb_ff <= 3'd1;
                  st_ff <= (keep_ff >= 3'd2) ? ST_PAIR : ST_STORE;
               end else begin
                  if (lhs >= {1'b0, new_ff.time_stamp}) begin
                     win_rec_ff[keep_ff] <= win_rec_ff[idx_ff];
                     keep_ff <= keep_ff + 1'b1;
                  end
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_PAIR: begin
               if (pend_ff && (distinct || last_pair)) begin
                  pend_ff <= 1'b0; olast_ff <= !distinct;
               end
               if (distinct) begin
                  haddr_ff <= paddr; rk_ff[0] <= ra; rk_ff[1] <= rb; rk_ff[2] <= rc;
                  st_ff <= ST_RDWAIT;
               end else if (last_pair) begin
                  st_ff <= ST_STORE;
               end else if (pb_next >= fill_ff) begin
                  pa_ff <= pa_ff + 1'b1; pb_ff <= pa_ff + 3'd2;
               end else pb_ff <= pb_next;
            end
            ST_RDWAIT: st_ff <= ST_UPDATE;
            ST_UPDATE: begin
               cnt_ff <= (ram_rd == CountCap) ? ram_rd : ram_rd + 32'd1;
               total_ff <= total_ff + 64'd1; emit_ff <= 2'd0; st_ff <= ST_EMIT;
            end
            ST_EMIT: if (out_free) begin
               out_ff <= {62'd0, ovf_ff, total_ff, cnt_ff, pos_sel,
                          mem_sel.word_forty, mem_sel.word_thirtytwo,
                          mem_sel.word_twentyfour, mem_sel.word_seventeen,
                          mem_sel.channel_byte, mem_sel.word_eight, mem_sel.time_stamp};
               olast_ff <= (emit_ff == 2'd2) && last_pair;
               emit_ff <= emit_ff + 2'd1;
               if (emit_ff == 2'd2) begin
                  pend_ff <= !last_pair;
                  if (last_pair) st_ff <= ST_STORE;
                  else begin
                     st_ff <= ST_PAIR;
                     if (pb_next >= fill_ff) begin
                        pa_ff <= pa_ff + 1'b1; pb_ff <= pa_ff + 3'd2;
                     end else pb_ff <= pb_next;
                  end
               end
            end
            ST_STORE: begin
               st_ff <= ST_IDLE;
               if (new_ff.channel_byte[7:1] < 7'(NumChannels - 1) ||
                   new_ff.channel_byte[7:1] == 7'(NumChannels - 1)) begin
                  if (fill_ff == 3'(WindowDepth)) begin
                     for (int i = 0; i < WindowDepth - 1; i++)
                        win_rec_ff[i] <= win_rec_ff[i + 1];
                     win_rec_ff[WindowDepth - 1] <= new_ff;
                     ovf_ff <= 1'b1;
                  end else begin
                     win_rec_ff[fill_ff] <= new_ff;
                     fill_ff <= fill_ff + 1'b1;
                  end
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> st_ff == ST_IDLE) else $error("ready outside idle");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 3'(WindowDepth)) else $error("fill overflow");
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(ovf_ff) && !$past(reset) |-> ovf_ff) else $error("overflow cleared");
endmodule
